// ----- hdl/frp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_pkg
// Shared constants and types for the Fletcher reply parser.
// ----------------------------------------------------------------------------
package frp_pkg;

	localparam logic [7:0] SYNC_FIRST       = 8'h75;
	localparam logic [7:0] SYNC_SECOND      = 8'h65;
	localparam logic [7:0] DESCRIPTOR_RESET = 8'h01;
	localparam logic [7:0] ACK_ZERO         = 8'h00;

	// One finished packet as it leaves the parser core.
	typedef struct packed {
		logic       valid;
		logic       checksum_ok;
		logic       ack_ok;
		logic [7:0] payload_length;
	} frp_result_t;

endpackage

// ----- hdl/fletcher_reply_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fletcher_reply_parser
// Byte-serial parser for sync-framed reply packets with a Fletcher-style 16-bit check whose sums wrap modulo 256.
// ----------------------------------------------------------------------------
// The parser accepts one received byte per clock cycle while in_stall is low
// and gives one result beat per completed packet. The last check byte is held
// in the input register, and the result beat is registered in the output
// register when that byte moves on. The packet state machine and both Fletcher
// sums update once per byte, so the sustained rate is one byte per cycle; it
// drops only while a finished result waits in the output register and the
// next packet is also complete. The expected descriptor is written through
// cfg_wr_en and cfg_wr_data and resets to 1; the user must write it only while
// no byte is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fletcher_reply_parser import frp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       checksum_ok,
	output logic       ack_ok,
	output logic [7:0] payload_length
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        at_last_byte;
	logic        out_free;
	logic [7:0]  descriptor_q;
	frp_result_t result;

	// Descriptor register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descriptor_q <= DESCRIPTOR_RESET;
		end else if (cfg_wr_en) begin
			descriptor_q <= cfg_wr_data;
		end
	end

	// A held beat moves on unless it completes a packet with the output full.
	assign advance = valid_s1 && (!at_last_byte || out_free);

	frp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	frp_core u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step_en             (advance),
		.byte_s1             (byte_s1),
		.expected_descriptor (descriptor_q),
		.at_last_byte        (at_last_byte),
		.result              (result)
	);

	frp_out_stage u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.result         (result),
		.free           (out_free),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.checksum_ok    (checksum_ok),
		.ack_ok         (ack_ok),
		.payload_length (payload_length)
	);

	// The input side stalls only behind a full result register and a final byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && at_last_byte && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// A new result always comes from a byte held in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && at_last_byte))
		else $error("result appeared without a completing byte");

	// A completed packet is never dropped while the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !out_free) |-> 1'b0)
		else $error("result produced while output register is full");

endmodule

// ----- hdl/frp_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_in_stage
// Input register that holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module frp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// The stage is stalled only while it holds a beat that cannot move on.
	assign in_stall = valid_s1 && !advance;

	// Valid flag of the held beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the held beat.
	always_ff @(posedge clk) begin
		if ((!valid_s1 || advance) && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ----- hdl/frp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_core
// Packet state machine and Fletcher sums; processes one byte per step.
// ----------------------------------------------------------------------------
module frp_core import frp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  byte_s1,
	input  logic [7:0]  expected_descriptor,
	output logic        at_last_byte,
	output frp_result_t result
);

	localparam logic [2:0] PH_HUNT1   = 3'd0;
	localparam logic [2:0] PH_HUNT2   = 3'd1;
	localparam logic [2:0] PH_DESC    = 3'd2;
	localparam logic [2:0] PH_LEN     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CHECK1  = 3'd5;
	localparam logic [2:0] PH_CHECK2  = 3'd6;

	logic [2:0] phase_q,      phase_d;
	logic [7:0] sum_first_q,  sum_first_d;
	logic [7:0] sum_second_q, sum_second_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] length_q,     length_d;
	logic [7:0] before_q,     before_d;
	logic [7:0] check1_q,     check1_d;
	logic [7:0] add_first;
	logic [7:0] add_second;

	// Running Fletcher sums with the current byte folded in.
	assign add_first  = sum_first_q + byte_s1;
	assign add_second = sum_second_q + add_first;

	// The second check byte is the only one that completes a packet.
	assign at_last_byte = (phase_q == PH_CHECK2);

	assign result.valid          = step_en && at_last_byte;
	assign result.checksum_ok    = (check1_q == sum_first_q) && (byte_s1 == sum_second_q);
	assign result.ack_ok         = (before_q == ACK_ZERO);
	assign result.payload_length = length_q;

	// Next-state logic for one received byte.
	always_comb begin
		phase_d      = phase_q;
		sum_first_d  = sum_first_q;
		sum_second_d = sum_second_q;
		bytes_left_d = bytes_left_q;
		length_d     = length_q;
		before_d     = before_q;
		check1_d     = check1_q;
		case (phase_q)
			PH_HUNT2: begin
				if (byte_s1 == SYNC_SECOND) begin
					sum_first_d  = add_first;
					sum_second_d = add_second;
					phase_d      = PH_DESC;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_DESC: begin
				if (byte_s1 == expected_descriptor) begin
					sum_first_d  = add_first;
					sum_second_d = add_second;
					phase_d      = PH_LEN;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_LEN: begin
				sum_first_d  = add_first;
				sum_second_d = add_second;
				length_d     = byte_s1;
				bytes_left_d = byte_s1;
				before_d     = byte_s1;
				phase_d      = (byte_s1 == 8'd0) ? PH_CHECK1 : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_first_d  = add_first;
				sum_second_d = add_second;
				before_d     = byte_s1;
				bytes_left_d = bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					phase_d = PH_CHECK1;
				end
			end
			PH_CHECK1: begin
				check1_d = byte_s1;
				phase_d  = PH_CHECK2;
			end
			PH_CHECK2: begin
				phase_d = PH_HUNT1;
			end
			default: begin
				// Hunting the first sync byte; a new packet restarts the sums.
				phase_d = PH_HUNT1;
				if (byte_s1 == SYNC_FIRST) begin
					sum_first_d  = SYNC_FIRST;
					sum_second_d = SYNC_FIRST;
					phase_d      = PH_HUNT2;
				end
			end
		endcase
	end

	// State registers advance once per consumed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT1;
			sum_first_q  <= 8'd0;
			sum_second_q <= 8'd0;
			bytes_left_q <= 8'd0;
			length_q     <= 8'd0;
			before_q     <= 8'd0;
			check1_q     <= 8'd0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			sum_first_q  <= sum_first_d;
			sum_second_q <= sum_second_d;
			bytes_left_q <= bytes_left_d;
			length_q     <= length_d;
			before_q     <= before_d;
			check1_q     <= check1_d;
		end
	end

endmodule

// ----- hdl/frp_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_out_stage
// Result register that holds a finished packet until the receiver takes it.
// ----------------------------------------------------------------------------
module frp_out_stage import frp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frp_result_t result,
	output logic        free,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        checksum_ok,
	output logic        ack_ok,
	output logic [7:0]  payload_length
);

	// The register can take a new beat when empty or when it is drained now.
	assign free = !out_valid || !out_stall;

	// Valid flag of the held result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= result.valid;
		end
	end

	// Result fields.
	always_ff @(posedge clk) begin
		if (free && result.valid) begin
			checksum_ok    <= result.checksum_ok;
			ack_ok         <= result.ack_ok;
			payload_length <= result.payload_length;
		end
	end

endmodule
